// ===== rtl/core/i2cfs_pkg.sv =====
// Shared types and codes for the I2C master frame sequencer.
// Used by the control, top-level and checker files; no dependencies.
package i2cfs_pkg;

  // Buffer position is wide enough for a full write run plus a full read run.
  localparam int POS_W  = 6;
  localparam int LEN_W  = 5;
  localparam int TICK_W = 16;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  // Input item kinds, carried on the slave-side tuser.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_EVENT = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_TIMEOUT   = 4'd1;
  localparam logic [3:0] ERR_START     = 4'd2;
  localparam logic [3:0] ERR_ADDR_WR   = 4'd3;
  localparam logic [3:0] ERR_DATA_WR   = 4'd4;
  localparam logic [3:0] ERR_RESTART   = 4'd5;
  localparam logic [3:0] ERR_ADDR_RD   = 4'd6;
  localparam logic [3:0] ERR_READ_ACK  = 4'd7;
  localparam logic [3:0] ERR_READ_NACK = 4'd8;

  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0]       buffer_index;
    logic [7:0]       buffer_byte;
    logic [6:0]       slave_address;
    logic [LEN_W-1:0] write_length;
    logic [LEN_W-1:0] read_length;
    logic [7:0]       status_code;
    logic [7:0]       received_byte;
  } item_t;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       frame_done;
    logic [3:0] error_code;
  } result_t;

endpackage

// ===== rtl/core/i2c_master_frame_sequencer.sv =====
// Top level of the I2C master frame sequencer: stream ports, input and result registers.
// Depends on i2cfs_pkg, i2cfs_ctrl and i2cfs_buffer.
//
// This block drives one combined write-then-read I2C master frame over a byte-level bus
// engine. Each input transaction is a buffer load, a frame start, an engine status event
// or a timer tick, selected by s_axis_tuser; each one yields exactly one result
// transaction carrying the next engine command, any received byte and, on the last
// transaction of a frame (m_axis_tlast), the error code. The block takes one transaction
// per clock cycle while the result register is free or being drained: an item lands in
// the input register, the single decision stage evaluates it against the frame state,
// and the outcome is held in the result register, from which m_axis_tvalid is driven.
// The decision stage reads the buffer through its registered read port, which
// prefetches the entry at the next buffer position. The buffer holds no reset
// contents and needs no clearing pass; an entry reads back only what a load or a
// received byte put there. The timeout limit is written through cfg_we_i and cfg_wdata_i
// while the block is idle; the user is bound to this, the block itself does not enforce it.
module i2c_master_frame_sequencer import i2cfs_pkg::*; #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // buffer_index[3:0], buffer_byte[11:4], slave_address[18:12], write_length[23:19],
  // read_length[28:24], status_code[36:29], received_byte[44:37], zero fill above.
  input  logic [47:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_byte[7:0], rx_byte[15:8], error_code[19:16], zero fill above.
  output logic [23:0] m_axis_tdata,
  // command[2:0], rx_valid[3]
  output logic [3:0]  m_axis_tuser,
  // frame_done
  output logic        m_axis_tlast
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic              in_vld_q;
  item_t             in_q;
  logic              out_vld_q;
  result_t           out_q;
  logic [TICK_W-1:0] limit_q;

  logic              advance;
  logic              go;
  result_t           res;
  logic              buf_wr_en;
  logic [AW-1:0]     buf_wr_addr;
  logic [7:0]        buf_wr_data;
  logic [AW-1:0]     buf_rd_addr;
  logic [7:0]        buf_rd_data;

  // The held item is decided whenever the result register is free or being emptied.
  assign advance       = !out_vld_q || m_axis_tready;
  assign go            = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.mode          <= s_axis_tuser;
      in_q.buffer_index  <= s_axis_tdata[3:0];
      in_q.buffer_byte   <= s_axis_tdata[11:4];
      in_q.slave_address <= s_axis_tdata[18:12];
      in_q.write_length  <= s_axis_tdata[23:19];
      in_q.read_length   <= s_axis_tdata[28:24];
      in_q.status_code   <= s_axis_tdata[36:29];
      in_q.received_byte <= s_axis_tdata[44:37];
    end
  end

  i2cfs_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .go_i            (go),
    .item_i          (in_q),
    .timeout_limit_i (limit_q),
    .buf_rd_data_i   (buf_rd_data),
    .buf_wr_en_o     (buf_wr_en),
    .buf_wr_addr_o   (buf_wr_addr),
    .buf_wr_data_o   (buf_wr_data),
    .buf_rd_addr_o   (buf_rd_addr),
    .result_o        (res)
  );

  i2cfs_buffer #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_buffer (
    .clk_i     (clk_i),
    .wr_en_i   (buf_wr_en),
    .wr_addr_i (buf_wr_addr),
    .wr_data_i (buf_wr_data),
    .rd_addr_i (buf_rd_addr),
    .rd_data_o (buf_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.error_code, out_q.rx_byte, out_q.tx_byte};
  assign m_axis_tuser  = {out_q.rx_valid, out_q.command};
  assign m_axis_tlast  = out_q.frame_done;

endmodule

// ===== rtl/core/i2cfs_buffer.sv =====
// Frame data buffer: one write port and one registered read port.
// The read address is the next buffer position, so data is prefetched before it is needed.
// Depends on nothing but its parameters.
module i2cfs_buffer #(
  parameter int BUFFER_DEPTH = 16,
  parameter int AW           = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A write to the address being fetched is forwarded so the prefetch is never stale.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/i2cfs_ctrl.sv =====
// Frame phase control: checks engine status, picks the next engine command.
// Depends on i2cfs_pkg; drives the write and prefetch ports of i2cfs_buffer.
module i2cfs_ctrl import i2cfs_pkg::*; #(
  parameter int BUFFER_DEPTH = 16,
  parameter int AW           = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  item_t             item_i,
  input  logic [TICK_W-1:0] timeout_limit_i,
  input  logic [7:0]        buf_rd_data_i,
  output logic              buf_wr_en_o,
  output logic [AW-1:0]     buf_wr_addr_o,
  output logic [7:0]        buf_wr_data_o,
  output logic [AW-1:0]     buf_rd_addr_o,
  output result_t           result_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_ADDR_W  = 3'd2;
  localparam logic [2:0] PH_DATA_W  = 3'd3;
  localparam logic [2:0] PH_RESTART = 3'd4;
  localparam logic [2:0] PH_ADDR_R  = 3'd5;
  localparam logic [2:0] PH_READ    = 3'd6;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_ADDR_W_OK = 8'h18;
  localparam logic [7:0] ST_DATA_W_OK = 8'h28;
  localparam logic [7:0] ST_ADDR_R_OK = 8'h40;
  localparam logic [7:0] ST_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_NACK = 8'h58;

  localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

  logic [2:0]        phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  wl_q, wl_d;
  logic [LEN_W-1:0]  rl_q, rl_d;
  logic [6:0]        addr_q, addr_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;

  logic              pos_in_range;
  logic [POS_W-1:0]  wr_pos;
  logic [LEN_W-1:0]  rl_dec;
  logic [TICK_W-1:0] ticks_inc;
  logic [7:0]        read_status;
  logic [3:0]        read_err;
  result_t           res;

  assign pos_in_range = ({3'b000, pos_q} < DEPTH_W);
  assign rl_dec       = (rl_q != '0) ? rl_q - LEN_W'(1) : rl_q;
  assign ticks_inc    = (ticks_q != '1) ? ticks_q + TICK_W'(1) : ticks_q;
  assign read_status  = (rl_q > LEN_W'(1)) ? ST_DATA_ACK : ST_DATA_NACK;
  assign read_err     = (rl_q > LEN_W'(1)) ? ERR_READ_ACK : ERR_READ_NACK;

  always_comb begin
    phase_d       = phase_q;
    pos_d         = pos_q;
    wl_d          = wl_q;
    rl_d          = rl_q;
    addr_d        = addr_q;
    ticks_d       = ticks_q;
    res           = '0;
    res.command   = CMD_NONE;
    buf_wr_en_o   = 1'b0;
    buf_wr_data_o = item_i.buffer_byte;
    wr_pos        = {2'b00, item_i.buffer_index};

    if (go_i) begin
      case (item_i.mode)
        MODE_LOAD: begin
          buf_wr_en_o = ({5'b00000, item_i.buffer_index} < DEPTH_W);
        end
        MODE_START: begin
          if (phase_q == PH_IDLE) begin
            addr_d      = item_i.slave_address;
            wl_d        = item_i.write_length;
            rl_d        = item_i.read_length;
            pos_d       = '0;
            phase_d     = PH_START;
            res.command = CMD_START;
          end
        end
        MODE_EVENT: begin
          case (phase_q)
            PH_START: begin
              if (item_i.status_code != ST_START && item_i.status_code != ST_RESTART) begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
                res.error_code = ERR_START;
              end else if (wl_q != '0) begin
                phase_d     = PH_ADDR_W;
                res.command = CMD_SEND;
                res.tx_byte = {addr_q, 1'b0};
              end else if (rl_q != '0) begin
                phase_d     = PH_ADDR_R;
                res.command = CMD_SEND;
                res.tx_byte = {addr_q, 1'b1};
              end else begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
              end
            end
            PH_ADDR_W: begin
              if (item_i.status_code != ST_ADDR_W_OK) begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
                res.error_code = ERR_ADDR_WR;
              end else begin
                phase_d     = PH_DATA_W;
                pos_d       = pos_q + POS_W'(1);
                wl_d        = wl_q - LEN_W'(1);
                res.command = CMD_SEND;
                res.tx_byte = pos_in_range ? buf_rd_data_i : 8'h00;
              end
            end
            PH_DATA_W: begin
              if (item_i.status_code != ST_DATA_W_OK) begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
                res.error_code = ERR_DATA_WR;
              end else if (wl_q != '0) begin
                pos_d       = pos_q + POS_W'(1);
                wl_d        = wl_q - LEN_W'(1);
                res.command = CMD_SEND;
                res.tx_byte = pos_in_range ? buf_rd_data_i : 8'h00;
              end else if (rl_q != '0) begin
                phase_d     = PH_RESTART;
                res.command = CMD_START;
              end else begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
              end
            end
            PH_RESTART: begin
              if (item_i.status_code != ST_RESTART) begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
                res.error_code = ERR_RESTART;
              end else begin
                phase_d     = PH_ADDR_R;
                res.command = CMD_SEND;
                res.tx_byte = {addr_q, 1'b1};
              end
            end
            PH_ADDR_R: begin
              if (item_i.status_code != ST_ADDR_R_OK) begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
                res.error_code = ERR_ADDR_RD;
              end else begin
                phase_d     = PH_READ;
                res.command = (rl_q > LEN_W'(1)) ? CMD_ACK : CMD_NACK;
              end
            end
            PH_READ: begin
              if (item_i.status_code != read_status) begin
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.frame_done = 1'b1;
                res.error_code = read_err;
              end else begin
                // Store the byte behind the written ones, if it still fits.
                buf_wr_en_o   = pos_in_range;
                buf_wr_data_o = item_i.received_byte;
                wr_pos        = pos_q;
                pos_d         = pos_q + POS_W'(1);
                rl_d          = rl_dec;
                res.rx_byte   = item_i.received_byte;
                res.rx_valid  = 1'b1;
                if (rl_dec == '0) begin
                  phase_d        = PH_IDLE;
                  res.command    = CMD_STOP;
                  res.frame_done = 1'b1;
                end else begin
                  res.command = (rl_dec > LEN_W'(1)) ? CMD_ACK : CMD_NACK;
                end
              end
            end
            default: begin
              res.command = CMD_NONE;
            end
          endcase
        end
        MODE_TICK: begin
          if (phase_q != PH_IDLE) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= timeout_limit_i) begin
              phase_d        = PH_IDLE;
              res.command    = CMD_STOP;
              res.frame_done = 1'b1;
              res.error_code = ERR_TIMEOUT;
            end
          end
        end
        default: begin
          res.command = CMD_NONE;
        end
      endcase

      // Any issued command restarts the wait for the next engine event.
      if (res.command != CMD_NONE) begin
        ticks_d = '0;
      end
    end
  end

  assign buf_wr_addr_o = AW'(wr_pos);
  assign buf_rd_addr_o = AW'(pos_d);
  assign result_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      wl_q    <= '0;
      rl_q    <= '0;
      addr_q  <= '0;
      ticks_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      wl_q    <= wl_d;
      rl_q    <= rl_d;
      addr_q  <= addr_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// ===== rtl/core/i2cfs_checker.sv =====
// Port-level checks for the I2C master frame sequencer, bound to its top level.
// Depends on i2cfs_pkg and i2c_master_frame_sequencer.
module i2cfs_checker import i2cfs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A frame ends only with a stop command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[2:0] == CMD_STOP))
    else $error("frame end without stop command");

  // An error code is reported only on the last transaction of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[19:16] != ERR_OK)) |-> m_axis_tlast)
    else $error("error code outside frame end");

  // A received byte comes only with a receive or the closing stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |->
      (m_axis_tuser[2:0] == CMD_ACK || m_axis_tuser[2:0] == CMD_NACK ||
       m_axis_tuser[2:0] == CMD_STOP))
    else $error("received byte with unexpected command");

  // The input side stalls only when a result is being held back downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind i2c_master_frame_sequencer i2cfs_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
